@@ rtl/gad_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gad_pkg
// Shared types and constants for the gamepad action detector.
// ----------------------------------------------------------------------------
package gad_pkg;

    // Full-scale squared stick travel; thresholds at or above it disable sticks.
    localparam logic [32:0] STICK_FULL_SCALE_SQ = 33'd1073676289;

    // Reset values of the configuration registers.
    localparam logic [32:0] STICK_THR_RESET = 33'd107321;
    localparam logic [7:0]  TRIG_THR_RESET  = 8'd2;

    // Register select codes, taken from the doubleword address bit.
    localparam logic REG_STICK_THR = 1'b0;
    localparam logic REG_TRIG_THR  = 1'b1;

    // One polled controller sample.
    typedef struct packed {
        logic               read_ok;
        logic [31:0]        packet_number;
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic [7:0]         left_trigger;
        logic [7:0]         right_trigger;
        logic [15:0]        buttons;
    } sample_t;

    // Stored reference sample.
    typedef struct packed {
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic [7:0]         left_trigger;
        logic [7:0]         right_trigger;
        logic [15:0]        buttons;
    } reference_t;

    // Thresholds from the configuration port.
    typedef struct packed {
        logic [32:0] stick_thr_sq;
        logic [7:0]  trigger_thr;
    } cfg_t;

    // Outcome of comparing one sample with the reference.
    typedef struct packed {
        logic processed;
        logic action;
        logic update;
    } decision_t;

endpackage

@@ rtl/gamepad_action_detector_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_action_detector_unit
// Detects player actions in a stream of polled controller samples.
//
//  Channel  | Direction | Contents
//  ---------+-----------+----------------------------------------------------
//  s_axis   | in        | one controller sample per item
//  m_axis   | out       | action flag, reference flag and running action count
//  apb      | in/out    | stick and trigger thresholds (0x0, 0x8)
//
// Each item passes through the input register and then the result register;
// one item is taken every cycle while the result channel is not stalled.
// The rate is set by the reference update loop: compare and update of the
// reference finish in the same cycle as an item leaves the input register.
// A stalled result holds while the input register can still take one item.
// Reset (synchronous, active low) clears the reference, packet and count.
// ----------------------------------------------------------------------------
module gamepad_action_detector_unit (
    input  logic         aclk,
    input  logic         aresetn,
    // Sample channel.
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: packet_number, left_x, left_y, right_x, right_y,
    //        left_trigger, right_trigger, buttons
    input  logic [127:0] s_tdata,
    // tuser: read_ok
    input  logic [0:0]   s_tuser,
    // Result channel.
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: action_total
    output logic [31:0]  m_tdata,
    // tuser: action, reference_updated
    output logic [1:0]   m_tuser,
    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    gad_pkg::cfg_t       cfg;
    gad_pkg::sample_t    in_reg;
    logic                in_valid_reg;
    gad_pkg::reference_t ref_reg;
    logic [31:0]         seen_packet_reg;
    logic [31:0]         count_reg;
    logic [31:0]         count_next;
    gad_pkg::decision_t  decision;
    logic                out_valid_reg;
    logic                act_reg;
    logic                upd_reg;
    logic                advance;
    logic                out_load;

    gad_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gad_detect u_detect (
        .sample      (in_reg),
        .ref_in      (ref_reg),
        .seen_packet (seen_packet_reg),
        .cfg         (cfg),
        .decision    (decision)
    );

    // Pipeline flow: the result register frees up when it is empty or taken.
    assign advance  = !out_valid_reg || m_tready;
    assign out_load = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.read_ok       <= s_tuser[0];
            in_reg.packet_number <= s_tdata[31:0];
            in_reg.left_x        <= s_tdata[47:32];
            in_reg.left_y        <= s_tdata[63:48];
            in_reg.right_x       <= s_tdata[79:64];
            in_reg.right_y       <= s_tdata[95:80];
            in_reg.left_trigger  <= s_tdata[103:96];
            in_reg.right_trigger <= s_tdata[111:104];
            in_reg.buttons       <= s_tdata[127:112];
        end
    end

    assign count_next = decision.action ? count_reg + 32'd1 : count_reg;

    // Reference, packet and count state advance as an item leaves the input.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg         <= '0;
            seen_packet_reg <= 32'd0;
            count_reg       <= 32'd0;
        end else if (out_load) begin
            count_reg <= count_next;
            if (decision.processed) begin
                seen_packet_reg <= in_reg.packet_number;
            end
            if (decision.update) begin
                ref_reg.left_x        <= in_reg.left_x;
                ref_reg.left_y        <= in_reg.left_y;
                ref_reg.right_x       <= in_reg.right_x;
                ref_reg.right_y       <= in_reg.right_y;
                ref_reg.left_trigger  <= in_reg.left_trigger;
                ref_reg.right_trigger <= in_reg.right_trigger;
                ref_reg.buttons       <= in_reg.buttons;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            act_reg <= decision.action;
            upd_reg <= decision.update;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = count_reg;
    assign m_tuser  = {upd_reg, act_reg};

    // A counted action always bumps the running total by one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && decision.action) |=> (count_reg == $past(count_reg) + 32'd1))
        else $error("action total did not advance on an action");

    // An action always comes with a reference update.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tuser[0] || m_tuser[1]))
        else $error("action reported without reference update");

    // A skipped sample leaves the recorded packet number alone.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && !decision.processed) |=> $stable(seen_packet_reg))
        else $error("packet number changed on a skipped sample");

    // A waiting result shows the current count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(count_reg))
        else $error("action count changed under a stalled result");

endmodule

@@ rtl/gad_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gad_cfg_regs
// APB-style register file holding the stick and trigger thresholds.
// ----------------------------------------------------------------------------
module gad_cfg_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    output gad_pkg::cfg_t     cfg
);

    logic [32:0] stick_thr_reg;
    logic [7:0]  trig_thr_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes; the doubleword address bit selects the register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stick_thr_reg <= gad_pkg::STICK_THR_RESET;
            trig_thr_reg  <= gad_pkg::TRIG_THR_RESET;
        end else if (wr_en) begin
            if (paddr[3] == gad_pkg::REG_STICK_THR) begin
                stick_thr_reg <= pwdata[32:0];
            end else begin
                trig_thr_reg <= pwdata[7:0];
            end
        end
    end

    // Read mux.
    always_comb begin
        if (paddr[3] == gad_pkg::REG_STICK_THR) begin
            prdata = {31'd0, stick_thr_reg};
        end else begin
            prdata = {56'd0, trig_thr_reg};
        end
    end

    assign cfg.stick_thr_sq = stick_thr_reg;
    assign cfg.trigger_thr  = trig_thr_reg;

endmodule

@@ rtl/gad_detect.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gad_detect
// Compares one sample with the reference and decides change and action.
// ----------------------------------------------------------------------------
module gad_detect (
    input  gad_pkg::sample_t    sample,
    input  gad_pkg::reference_t ref_in,
    input  logic [31:0]         seen_packet,
    input  gad_pkg::cfg_t       cfg,
    output gad_pkg::decision_t  decision
);

    logic signed [16:0] dlx, dly, drx, dry;
    logic signed [33:0] sq_lx, sq_ly, sq_rx, sq_ry;
    logic [33:0]        dist_left, dist_right;
    logic               stick_enabled;
    logic               left_moved, right_moved;
    logic [7:0]         dlt, drt;
    logic               lt_moved, rt_moved;
    logic               analog, btn_change, btn_press;

    // Stick deltas and their squares; each square fits in 33 bits.
    assign dlx   = 17'(sample.left_x)  - 17'(ref_in.left_x);
    assign dly   = 17'(sample.left_y)  - 17'(ref_in.left_y);
    assign drx   = 17'(sample.right_x) - 17'(ref_in.right_x);
    assign dry   = 17'(sample.right_y) - 17'(ref_in.right_y);
    assign sq_lx = dlx * dlx;
    assign sq_ly = dly * dly;
    assign sq_rx = drx * drx;
    assign sq_ry = dry * dry;

    assign dist_left  = 34'(unsigned'(sq_lx[32:0])) + 34'(unsigned'(sq_ly[32:0]));
    assign dist_right = 34'(unsigned'(sq_rx[32:0])) + 34'(unsigned'(sq_ry[32:0]));

    // A threshold at or above full scale turns stick detection off.
    assign stick_enabled = cfg.stick_thr_sq < gad_pkg::STICK_FULL_SCALE_SQ;
    assign left_moved    = stick_enabled && (dist_left  > {1'b0, cfg.stick_thr_sq});
    assign right_moved   = stick_enabled && (dist_right > {1'b0, cfg.stick_thr_sq});

    // Absolute trigger movement.
    assign dlt = (sample.left_trigger >= ref_in.left_trigger) ?
                 sample.left_trigger - ref_in.left_trigger :
                 ref_in.left_trigger - sample.left_trigger;
    assign drt = (sample.right_trigger >= ref_in.right_trigger) ?
                 sample.right_trigger - ref_in.right_trigger :
                 ref_in.right_trigger - sample.right_trigger;
    assign lt_moved = dlt > cfg.trigger_thr;
    assign rt_moved = drt > cfg.trigger_thr;

    assign analog     = left_moved || right_moved || lt_moved || rt_moved;
    assign btn_change = sample.buttons != ref_in.buttons;
    assign btn_press  = (sample.buttons & ~ref_in.buttons) != 16'd0;

    // Only a good read with a fresh packet number is looked at.
    always_comb begin
        decision.processed = sample.read_ok && (sample.packet_number != seen_packet);
        decision.update    = decision.processed && (analog || btn_change);
        decision.action    = decision.processed && (analog || btn_press);
    end

endmodule

@@ dv/gad_action_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gad_action_checker
// Passive checker for the gamepad action detector. It tracks the thresholds
// written over the configuration port, keeps its own reference sample,
// packet number and action count, predicts the outcome of every sample the
// block accepts and compares each result item against the oldest prediction.
// ----------------------------------------------------------------------------
module gad_action_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    // tdata: packet_number, left_x, left_y, right_x, right_y,
    //        left_trigger, right_trigger, buttons
    input  logic [127:0] s_tdata,
    // tuser: read_ok
    input  logic [0:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    // tdata: action_total
    input  logic [31:0]  m_tdata,
    // tuser: action, reference_updated
    input  logic [1:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    input  logic         pready,
    output int           mismatches,
    output int           pending
);

    // Outcome of one sample as the result channel reports it.
    typedef struct packed {
        logic        action;
        logic        ref_updated;
        logic [31:0] total;
    } action_report_t;

    gad_pkg::cfg_t       thresholds;
    gad_pkg::reference_t held_ref;
    logic [31:0]         last_packet;
    logic [31:0]         action_count;
    action_report_t      awaited_reports[$];
    action_report_t      oldest;
    gad_pkg::sample_t    taken;

    // A stick has moved once its squared travel exceeds the threshold. A
    // threshold at full scale or above switches stick detection off.
    function automatic logic stick_far(input logic signed [15:0] x,
                                       input logic signed [15:0] y,
                                       input logic signed [15:0] x0,
                                       input logic signed [15:0] y0);
        longint          dx;
        longint          dy;
        longint unsigned dist_sq;
        dx      = longint'(x) - longint'(x0);
        dy      = longint'(y) - longint'(y0);
        dist_sq = dx * dx + dy * dy;
        return (thresholds.stick_thr_sq < gad_pkg::STICK_FULL_SCALE_SQ) &&
               (dist_sq > thresholds.stick_thr_sq);
    endfunction

    function automatic logic trigger_far(input logic [7:0] lvl, input logic [7:0] lvl0);
        logic [7:0] diff;
        diff = (lvl >= lvl0) ? lvl - lvl0 : lvl0 - lvl;
        return diff > thresholds.trigger_thr;
    endfunction

    // Works out the result of one sample and advances the tracked state.
    function automatic action_report_t detect_action(input gad_pkg::sample_t smp);
        action_report_t rpt;
        logic           analog;
        rpt.action      = 1'b0;
        rpt.ref_updated = 1'b0;
        if (smp.read_ok && smp.packet_number != last_packet) begin
            analog = stick_far(smp.left_x, smp.left_y, held_ref.left_x, held_ref.left_y) ||
                     stick_far(smp.right_x, smp.right_y,
                               held_ref.right_x, held_ref.right_y) ||
                     trigger_far(smp.left_trigger, held_ref.left_trigger) ||
                     trigger_far(smp.right_trigger, held_ref.right_trigger);
            if (analog || smp.buttons != held_ref.buttons) begin
                // A release alone moves the reference but is not an action.
                if (analog || (smp.buttons & ~held_ref.buttons) != '0) begin
                    rpt.action   = 1'b1;
                    action_count = action_count + 32'd1;
                end
                rpt.ref_updated        = 1'b1;
                held_ref.left_x        = smp.left_x;
                held_ref.left_y        = smp.left_y;
                held_ref.right_x       = smp.right_x;
                held_ref.right_y       = smp.right_y;
                held_ref.left_trigger  = smp.left_trigger;
                held_ref.right_trigger = smp.right_trigger;
                held_ref.buttons       = smp.buttons;
            end
            last_packet = smp.packet_number;
        end
        rpt.total = action_count;
        return rpt;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected 0x%0h, got 0x%0h", field, want, got);
        end
    endtask

    // Results are compared before new samples are predicted: a result never
    // belongs to the sample taken at the same edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            thresholds.stick_thr_sq = gad_pkg::STICK_THR_RESET;
            thresholds.trigger_thr  = gad_pkg::TRIG_THR_RESET;
            held_ref                = '0;
            last_packet             = '0;
            action_count            = '0;
            awaited_reports.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[2:0] == 3'b000) begin
                case (paddr[3])
                    gad_pkg::REG_STICK_THR: thresholds.stick_thr_sq = pwdata[32:0];
                    gad_pkg::REG_TRIG_THR:  thresholds.trigger_thr  = pwdata[7:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (awaited_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item: action_total 0x%0h", m_tdata);
                end else begin
                    oldest = awaited_reports.pop_front();
                    check_field("action", 32'(oldest.action), 32'(m_tuser[0]));
                    check_field("reference_updated", 32'(oldest.ref_updated),
                                32'(m_tuser[1]));
                    check_field("action_total", oldest.total, m_tdata);
                end
            end
            if (s_tvalid && s_tready) begin
                taken.read_ok       = s_tuser[0];
                taken.packet_number = s_tdata[31:0];
                taken.left_x        = s_tdata[47:32];
                taken.left_y        = s_tdata[63:48];
                taken.right_x       = s_tdata[79:64];
                taken.right_y       = s_tdata[95:80];
                taken.left_trigger  = s_tdata[103:96];
                taken.right_trigger = s_tdata[111:104];
                taken.buttons       = s_tdata[127:112];
                awaited_reports.push_back(detect_action(taken));
            end
        end
        pending = awaited_reports.size();
    end

endmodule

@@ dv/gamepad_action_detector_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_action_detector_unit_tb
// Drives controller samples into the action detector under several threshold
// settings: a directed set of corner cases, then random sticks, triggers,
// buttons and packet numbers, with random gaps and stalls on both channels
// and long result stalls. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module gamepad_action_detector_unit_tb;

    localparam int STALL_LIMIT     = 1000;
    localparam int HOLD_CYCLES     = 60;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int NUM_PHASES      = 7;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata  = '0;
    logic [0:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [3:0]   paddr    = '0;
    logic [63:0]  pwdata   = '0;
    logic [63:0]  prdata;
    logic         pready;

    int           check_errors;
    int           check_pending;

    // Stimulus state: the pad position being walked and the last packet sent.
    gad_pkg::sample_t pad = '0;
    logic [31:0]  last_pkt = '0;
    logic [15:0]  btn_base;
    logic [32:0]  stick_set;
    logic [7:0]   trig_set;
    int           ph;
    int           n;

    // Idling controls shared with the result side.
    logic         src_idle_en   = 1'b0;
    logic         sink_idle_en  = 1'b0;
    int           hold_requests = 0;
    int           hold_served   = 0;
    int           no_gap_left   = 0;
    int           stall_left    = 0;
    int           hold_left     = 0;
    int           idle_cycles   = 0;

    gamepad_action_detector_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    gad_action_checker action_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .mismatches (check_errors),
        .pending    (check_pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Result side: random stall bursts, plus a long hold-off on each request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 13) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    function automatic logic signed [15:0] walk(input logic signed [15:0] v, input int span);
        int t;
        t = int'(v) + int'($urandom_range(0, 2 * span)) - span;
        if (t > 32767)
            t = 32767;
        if (t < -32768)
            t = -32768;
        return t[15:0];
    endfunction

    function automatic logic [7:0] tweak(input logic [7:0] v, input int span);
        int t;
        t = int'(v) + int'($urandom_range(0, 2 * span)) - span;
        if (t > 255)
            t = 255;
        if (t < 0)
            t = 0;
        return t[7:0];
    endfunction

    // Builds one sample from plain values and makes it the current pad state.
    function automatic gad_pkg::sample_t mk(input logic ok, input logic [31:0] pkt,
                                   input int lx, input int ly, input int rx, input int ry,
                                   input int lt, input int rt, input logic [15:0] btn);
        gad_pkg::sample_t smp;
        smp.read_ok       = ok;
        smp.packet_number = pkt;
        smp.left_x        = 16'(lx);
        smp.left_y        = 16'(ly);
        smp.right_x       = 16'(rx);
        smp.right_y       = 16'(ry);
        smp.left_trigger  = 8'(lt);
        smp.right_trigger = 8'(rt);
        smp.buttons       = btn;
        pad               = smp;
        last_pkt          = pkt;
        return smp;
    endfunction

    // Next random sample: mostly a plausible evolution of the pad with fresh
    // packet numbers, with jumps, repeats, failed reads and pure noise mixed in.
    function automatic gad_pkg::sample_t next_sample();
        int pick;
        int span;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            span              = ($urandom_range(0, 3) == 0) ? 3000 : 400;
            pad.left_x        = walk(pad.left_x, span);
            pad.left_y        = walk(pad.left_y, span);
            pad.right_x       = walk(pad.right_x, span);
            pad.right_y       = walk(pad.right_y, span);
            pad.left_trigger  = tweak(pad.left_trigger, 5);
            pad.right_trigger = tweak(pad.right_trigger, 5);
            if ($urandom_range(0, 4) == 0)
                pad.buttons = pad.buttons ^ (16'd1 << $urandom_range(0, 15));
        end else if (pick < 70) begin
            case ($urandom_range(0, 6))
                0: pad.left_x        = 16'($urandom);
                1: pad.left_y        = 16'($urandom);
                2: pad.right_x       = 16'($urandom);
                3: pad.right_y       = 16'($urandom);
                4: pad.left_trigger  = 8'($urandom);
                5: pad.right_trigger = 8'($urandom);
                default: pad.buttons = 16'($urandom);
            endcase
        end else if (pick >= 82) begin
            pad[127:0] = {$urandom, $urandom, $urandom, $urandom};
        end
        pick = $urandom_range(0, 99);
        if (pick < 82)
            pad.packet_number = last_pkt + 32'd1;
        else if (pick < 90)
            pad.packet_number = last_pkt;
        else
            pad.packet_number = $urandom;
        pad.read_ok = ($urandom_range(0, 9) != 0);
        last_pkt    = pad.packet_number;
        return pad;
    endfunction

    // Offers one item and holds it until taken, then maybe leaves a gap.
    task automatic push_sample(input gad_pkg::sample_t smp);
        s_tvalid <= 1'b1;
        s_tuser  <= smp.read_ok;
        s_tdata  <= {smp.buttons, smp.right_trigger, smp.left_trigger, smp.right_y,
                     smp.right_x, smp.left_y, smp.left_x, smp.packet_number};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (no_gap_left > 0) begin
            no_gap_left--;
        end else if (src_idle_en && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    // Stops offering items until every predicted result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (check_pending != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic sel, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Full-scale swing of the left stick: a button change first pins the
    // reference, then the stick travels exactly full scale along one axis.
    task automatic full_swing_probe();
        push_sample(mk(1'b1, last_pkt + 32'd1, -32768, 0, -32768, 0,
                       pad.left_trigger, pad.right_trigger, ~pad.buttons));
        push_sample(mk(1'b1, last_pkt + 32'd1, -1, 0, -32768, 0,
                       pad.left_trigger, pad.right_trigger, pad.buttons));
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;

        // Corner cases under the reset thresholds.
        // Packet zero right after reset is taken as already seen.
        push_sample(mk(1'b1, 32'd0, 1000, 1000, 0, 0, 50, 50, 16'h0001));
        // A failed read is skipped.
        push_sample(mk(1'b0, 32'd7, 1000, 1000, 0, 0, 50, 50, 16'h0001));
        // Extreme positions, full triggers one side, every button pressed.
        push_sample(mk(1'b1, 32'd1, -32768, 32767, 32767, -32768, 255, 0, 16'hFFFF));
        // Repeated packet number with different content.
        push_sample(mk(1'b1, 32'd1, 0, 0, 0, 0, 0, 0, 16'h0000));
        push_sample(mk(1'b1, 32'd2, -32768, 32767, 32767, -32768, 255, 0, 16'hFFFF));
        // Release only, then a fresh press.
        push_sample(mk(1'b1, 32'd3, -32768, 32767, 32767, -32768, 255, 0, 16'h00FF));
        push_sample(mk(1'b1, 32'd4, -32768, 32767, 32767, -32768, 255, 0, 16'h01FF));
        // Stick travel just under and just over the default threshold.
        push_sample(mk(1'b1, 32'd5, -32468, 32667, 32767, -32768, 255, 0, 16'h01FF));
        push_sample(mk(1'b1, 32'd6, -32440, 32767, 32767, -32768, 255, 0, 16'h01FF));
        // Trigger travel equal to the threshold, then one more.
        push_sample(mk(1'b1, 32'd7, -32440, 32767, 32767, -32768, 253, 2, 16'h01FF));
        push_sample(mk(1'b1, 32'd8, -32440, 32767, 32767, -32768, 252, 2, 16'h01FF));
        // Largest packet number, everything flipped to the other extreme.
        push_sample(mk(1'b1, 32'hFFFF_FFFF, 32767, -32768, -32768, 32767, 0, 255, 16'h0000));
        push_sample(mk(1'b1, 32'hFFFF_FFFF, 5, 5, 5, 5, 5, 5, 16'h5555));
        // Packet zero is new once another number has been recorded.
        push_sample(mk(1'b1, 32'd0, 32767, -32768, -32768, 32767, 0, 255, 16'h0000));
        push_sample(mk(1'b0, 32'd1, 0, 0, 0, 0, 128, 128, 16'hAAAA));

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            case (ph)
                0: begin
                    stick_set = '0;
                    trig_set  = '0;
                end
                1: begin
                    stick_set = gad_pkg::STICK_FULL_SCALE_SQ - 33'd1;
                    trig_set  = 8'd255;
                end
                2: begin
                    stick_set = gad_pkg::STICK_FULL_SCALE_SQ;
                    trig_set  = 8'($urandom_range(0, 255));
                end
                3: begin
                    stick_set = 33'h1_FFFF_FFFF;
                    trig_set  = 8'd255;
                end
                4: begin
                    stick_set = 33'd100;
                    trig_set  = 8'd3;
                end
                5: begin
                    stick_set = 33'($urandom_range(0, 500000));
                    trig_set  = 8'($urandom_range(0, 16));
                end
                default: begin
                    stick_set = gad_pkg::STICK_THR_RESET;
                    trig_set  = gad_pkg::TRIG_THR_RESET;
                end
            endcase
            write_reg(gad_pkg::REG_STICK_THR, {31'd0, stick_set});
            write_reg(gad_pkg::REG_TRIG_THR, {56'd0, trig_set});

            if (ph >= 1 && ph <= 3)
                full_swing_probe();
            if (ph == 4) begin
                // Squared travel of 100 on an axis and a diagonal, then 101.
                btn_base = ~pad.buttons;
                push_sample(mk(1'b1, last_pkt + 32'd1, 32767, -32768, -32768, 32767,
                               0, 255, btn_base));
                push_sample(mk(1'b1, last_pkt + 32'd1, 32757, -32768, -32768, 32767,
                               0, 255, btn_base));
                push_sample(mk(1'b1, last_pkt + 32'd1, 32761, -32760, -32768, 32767,
                               0, 255, btn_base));
                push_sample(mk(1'b1, last_pkt + 32'd1, 32757, -32767, -32768, 32767,
                               0, 255, btn_base));
                push_sample(mk(1'b1, last_pkt + 32'd1, 32757, -32767, -32768, 32767,
                               3, 255, btn_base));
                push_sample(mk(1'b1, last_pkt + 32'd1, 32757, -32767, -32768, 32767,
                               4, 255, btn_base));
            end

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // The last phase runs with no idling on either side.
                if (n % 25 == 0) begin
                    src_idle_en  = (ph != NUM_PHASES - 1) && ($urandom_range(0, 2) != 0);
                    sink_idle_en = (ph != NUM_PHASES - 1) && ($urandom_range(0, 2) != 0);
                end
                // Long result stall while samples keep coming, so input backs up.
                if ((ph == 1 || ph == 5) && n == 40) begin
                    hold_requests++;
                    no_gap_left = 30;
                end
                if (ph == 3 && n == 60)
                    drain_results();
                push_sample(next_sample());
            end
        end

        drain_results();
        repeat (4) @(posedge aclk);
        if (check_errors == 0 && check_pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ gamepad_action_detector_unit.f @@
rtl/gad_pkg.sv
rtl/gad_cfg_regs.sv
rtl/gad_detect.sv
rtl/gamepad_action_detector_unit.sv
dv/gad_action_checker.sv
dv/gamepad_action_detector_unit_tb.sv
